>>> hw/rtl/knn_pkg.sv
// Shared types and constants for the k-nearest-neighbour density tracker.
// No dependencies; imported by every other file of the block.
package knn_pkg;

   localparam int DEF_MAX_POINTS     = 256;
   localparam int DEF_MAX_NEIGHBOURS = 8;
   localparam int DEF_MAX_COORDS     = 4;
   localparam int CMD_QUEUE_DEPTH    = 2;

   localparam int COORD_W   = 16;
   localparam int COORD_NUM = 4;
   localparam int ID_W      = 32;
   localparam int DIST_W    = 35;
   localparam int SQ_W      = 34;
   localparam int CNT_OUT_W = 9;
   localparam int IDX_OUT_W = 8;
   localparam int NC_W      = 3;
   localparam int NK_W      = 4;
   localparam int CSR_IDX_W = 1;
   localparam int CSR_DAT_W = 4;

   localparam logic [DIST_W-1:0] DIST_NONE = {DIST_W{1'b1}};
   localparam logic [NC_W-1:0]   NC_RESET  = 3'd4;
   localparam logic [NK_W-1:0]   NK_RESET  = 4'd8;

   localparam logic [CSR_IDX_W-1:0] CSR_NUM_COORDS     = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_NUM_NEIGHBOURS = 1'b1;

   typedef enum logic [1:0] {
      OP_ADD    = 2'd0,
      OP_CLEAR  = 2'd1,
      OP_QBEST  = 2'd2,
      OP_QWORST = 2'd3
   } op_type;

   typedef struct packed {
      op_type                            op;
      logic [ID_W-1:0]                   point_id;
      logic [COORD_NUM-1:0][COORD_W-1:0] coords;
   } cmd_type;

   typedef struct packed {
      logic [NC_W-1:0] eff_c;
      logic [NK_W-1:0] eff_k;
   } cfg_type;

   typedef struct packed {
      logic [CNT_OUT_W-1:0] entry_count;
      logic [IDX_OUT_W-1:0] entry_index;
      logic [DIST_W-1:0]    entry_dist;
      logic                 entry_valid;
      logic [IDX_OUT_W-1:0] neighbour_index;
      logic [ID_W-1:0]      neighbour_id;
      logic                 neighbour_valid;
      logic                 store_full;
      logic                 last;
   } rsp_type;

endpackage

>>> hw/rtl/knn_req_if.sv
// Request channel: valid/ready plus one command item.
// Depends on knn_pkg for field widths.
interface knn_req_if;
   import knn_pkg::*;
   logic                      valid;
   logic                      ready;
   logic [1:0]                op;
   logic [ID_W-1:0]           point_id;
   logic signed [COORD_W-1:0] coord0;
   logic signed [COORD_W-1:0] coord1;
   logic signed [COORD_W-1:0] coord2;
   logic signed [COORD_W-1:0] coord3;

   modport source (output valid, op, point_id, coord0, coord1, coord2, coord3,
                   input ready);
   modport sink   (input valid, op, point_id, coord0, coord1, coord2, coord3,
                   output ready);
endinterface

>>> hw/rtl/knn_rsp_if.sv
// Result channel: valid/ready plus one result item.
// Depends on knn_pkg for field widths.
interface knn_rsp_if;
   import knn_pkg::*;
   logic                 valid;
   logic                 ready;
   logic [CNT_OUT_W-1:0] entry_count;
   logic [IDX_OUT_W-1:0] entry_index;
   logic [DIST_W-1:0]    entry_dist;
   logic                 entry_valid;
   logic [IDX_OUT_W-1:0] neighbour_index;
   logic [ID_W-1:0]      neighbour_id;
   logic                 neighbour_valid;
   logic                 store_full;
   logic                 last;

   modport source (output valid, entry_count, entry_index, entry_dist, entry_valid,
                   neighbour_index, neighbour_id, neighbour_valid, store_full, last,
                   input ready);
   modport sink   (input valid, entry_count, entry_index, entry_dist, entry_valid,
                   neighbour_index, neighbour_id, neighbour_valid, store_full, last,
                   output ready);
endinterface

>>> hw/rtl/knn_cmd_fifo.sv
// Short command queue between the front and back parts.
// Depends on knn_pkg (cmd_type).
module knn_cmd_fifo #(
   parameter int DEPTH = knn_pkg::CMD_QUEUE_DEPTH
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   output logic              in_ready,
   input  knn_pkg::cmd_type  in_data,
   output logic              out_valid,
   input  logic              out_ready,
   output knn_pkg::cmd_type  out_data
);
   import knn_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   cmd_type              mem_ff [DEPTH];
   logic [PTR_W-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]     cnt_ff, cnt_in;
   logic                 push, pop;

   assign in_ready  = (cnt_ff != CNT_W'(DEPTH));
   assign out_valid = (cnt_ff != '0);
   assign out_data  = mem_ff[rd_ptr_ff];
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (push && !pop) begin
         cnt_in = cnt_ff + CNT_W'(1);
      end else if (pop && !push) begin
         cnt_in = cnt_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= in_data;
      end
   end

endmodule

>>> hw/rtl/knn_front.sv
// Front part: takes request transfers, decodes them into commands and
// holds the configuration registers. Depends on knn_pkg and knn_req_if.
module knn_front #(
   parameter int MAX_NEIGHBOURS = knn_pkg::DEF_MAX_NEIGHBOURS,
   parameter int MAX_COORDS     = knn_pkg::DEF_MAX_COORDS
) (
   input  logic                            clock,
   input  logic                            reset,
   knn_req_if.sink                         req,
   input  logic                            csr_we,
   input  logic [knn_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [knn_pkg::CSR_DAT_W-1:0]   csr_wdata,
   output logic                            cmd_valid,
   input  logic                            cmd_ready,
   output knn_pkg::cmd_type                cmd,
   output knn_pkg::cfg_type                cfg
);
   import knn_pkg::*;

   logic [NC_W-1:0] nc_ff;
   logic [NK_W-1:0] nk_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         nc_ff <= NC_RESET;
         nk_ff <= NK_RESET;
      end else if (csr_we) begin
         case (csr_index)
            CSR_NUM_COORDS:     nc_ff <= csr_wdata[NC_W-1:0];
            CSR_NUM_NEIGHBOURS: nk_ff <= csr_wdata[NK_W-1:0];
            default: ;
         endcase
      end
   end

   // out-of-range register values are clamped into the supported range
   always_comb begin
      if (nc_ff == '0) begin
         cfg.eff_c = NC_W'(1);
      end else if (int'(nc_ff) > MAX_COORDS) begin
         cfg.eff_c = NC_W'(MAX_COORDS);
      end else begin
         cfg.eff_c = nc_ff;
      end
      if (nk_ff == '0) begin
         cfg.eff_k = NK_W'(1);
      end else if (int'(nk_ff) > MAX_NEIGHBOURS) begin
         cfg.eff_k = NK_W'(MAX_NEIGHBOURS);
      end else begin
         cfg.eff_k = nk_ff;
      end
   end

   assign cmd_valid    = req.valid;
   assign req.ready    = cmd_ready;
   assign cmd.op       = op_type'(req.op);
   assign cmd.point_id = req.point_id;
   assign cmd.coords   = {req.coord3, req.coord2, req.coord1, req.coord0};

endmodule

>>> hw/rtl/knn_back.sv
// Back part: point store, neighbour lists, distance datapath, best tracking
// and the result output register. Depends on knn_pkg and knn_rsp_if.
module knn_back #(
   parameter int MAX_POINTS     = knn_pkg::DEF_MAX_POINTS,
   parameter int MAX_NEIGHBOURS = knn_pkg::DEF_MAX_NEIGHBOURS,
   parameter int MAX_COORDS     = knn_pkg::DEF_MAX_COORDS
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             cmd_valid,
   output logic             cmd_pop,
   input  knn_pkg::cmd_type cmd,
   input  knn_pkg::cfg_type cfg,
   knn_rsp_if.source        rsp
);
   import knn_pkg::*;

   localparam int IDX_W = $clog2(MAX_POINTS);
   localparam int CNT_W = $clog2(MAX_POINTS + 1);
   localparam int RK_W  = (MAX_NEIGHBOURS > 1) ? $clog2(MAX_NEIGHBOURS) : 1;

   typedef struct packed {
      logic              full;
      logic [IDX_W-1:0]  who;
      logic [DIST_W-1:0] sq_dist;
   } slot_type;
   typedef slot_type [MAX_NEIGHBOURS-1:0] row_type;
   typedef logic [MAX_COORDS-1:0][COORD_W-1:0] crow_type;

   typedef enum logic [13:0] {
      S_IDLE     = 14'b00000000000001,
      S_ADD_INIT = 14'b00000000000010,
      S_RD       = 14'b00000000000100,
      S_SQ       = 14'b00000000001000,
      S_SUM      = 14'b00000000010000,
      S_OFF_I    = 14'b00000000100000,
      S_OFF_N    = 14'b00000001000000,
      S_ADD_WB   = 14'b00000010000000,
      S_WS_RD    = 14'b00000100000000,
      S_WS_CMP   = 14'b00001000000000,
      S_Q_ROW    = 14'b00010000000000,
      S_Q_ID     = 14'b00100000000000,
      S_Q_OUT    = 14'b01000000000000,
      S_EMIT     = 14'b10000000000000
   } state_type;

   // farthest-first insertion; an equal distance lands on the farther side.
   // The scan stops at the first slot that is not farther, as slots past an
   // old K may hold empty entries after K grows.
   function automatic row_type offer_row(input row_type l, input logic [DIST_W-1:0] qa,
                                         input logic [IDX_W-1:0] who,
                                         input logic [NK_W-1:0] k);
      logic [MAX_NEIGHBOURS:0] lt;
      row_type                 r;
      slot_type                ns;
      ns.full    = 1'b1;
      ns.who     = who;
      ns.sq_dist = qa;
      lt = '0;
      lt[0] = 1'b1;
      for (int j = 1; j < MAX_NEIGHBOURS; j++) begin
         lt[j] = lt[j-1] && (j < int'(k)) && (qa < l[j].sq_dist);
      end
      for (int j = 0; j < MAX_NEIGHBOURS; j++) begin
         if (lt[j+1]) begin
            r[j] = l[j+1];
         end else if (j == 0 || lt[j]) begin
            r[j] = ns;
         end else begin
            r[j] = l[j];
         end
      end
      return r;
   endfunction

   state_type          state_ff, state_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic [DIST_W-1:0]  best_dist_ff, best_dist_in;
   logic [IDX_W-1:0]   best_idx_ff, best_idx_in;
   logic               best_valid_ff, best_valid_in;
   logic [IDX_W-1:0]   iter_ff, iter_in;
   logic [IDX_W-1:0]   new_idx_ff, new_idx_in;
   row_type            newl_ff, newl_in;
   logic [IDX_W-1:0]   q_idx_ff, q_idx_in;
   logic [DIST_W-1:0]  q_dist_ff, q_dist_in;
   logic               q_valid_ff, q_valid_in;
   logic [RK_W-1:0]    rank_ff, rank_in;
   logic               dropped_ff, dropped_in;
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_type            rsp_ff, rsp_in;

   logic [MAX_COORDS-1:0][SQ_W-1:0] sq_ff, sq_in;
   logic [DIST_W-1:0]               dist_ff, dist_in;

   crow_type           coord_mem [MAX_POINTS];
   logic [ID_W-1:0]    id_mem    [MAX_POINTS];
   row_type            list_mem  [MAX_POINTS];
   crow_type           coord_rd_ff;
   logic [ID_W-1:0]    id_rd_ff;
   row_type            list_rd_ff;

   logic [IDX_W-1:0]   rd_addr, id_addr, list_wa;
   logic               store_we, list_we;
   row_type            list_wd, off_i, off_n, empty_row;
   crow_type           coord_wd;
   logic               hit_i, hit_n, out_free, last_iter, nbr_ok;
   slot_type           q_slot;

   assign out_free  = !rsp_valid_ff || rsp.ready;
   assign rd_addr   = (state_ff == S_Q_ROW || state_ff == S_Q_ID || state_ff == S_Q_OUT)
                      ? q_idx_ff : iter_ff;
   assign q_slot    = list_rd_ff[rank_ff];
   assign id_addr   = q_slot.who;
   assign nbr_ok    = q_valid_ff && q_slot.full;
   assign off_i     = offer_row(list_rd_ff, dist_ff, new_idx_ff, cfg.eff_k);
   assign off_n     = offer_row(newl_ff, dist_ff, iter_ff, cfg.eff_k);
   assign hit_i     = dist_ff <= list_rd_ff[0].sq_dist;
   assign hit_n     = dist_ff <= newl_ff[0].sq_dist;
   assign last_iter = (CNT_W'(iter_ff) + CNT_W'(1)) == count_ff;

   always_comb begin
      for (int j = 0; j < MAX_NEIGHBOURS; j++) begin
         empty_row[j].full    = 1'b0;
         empty_row[j].who     = '0;
         empty_row[j].sq_dist = DIST_NONE;
      end
      for (int j = 0; j < MAX_COORDS; j++) begin
         coord_wd[j] = cmd.coords[j];
      end
   end

   // squared differences, then their sum: one registered stage each
   always_comb begin
      logic signed [COORD_W:0]   d;
      logic signed [2*COORD_W+1:0] p;
      dist_in = '0;
      for (int j = 0; j < MAX_COORDS; j++) begin
         d = $signed({coord_rd_ff[j][COORD_W-1], coord_rd_ff[j]})
             - $signed({cmd.coords[j][COORD_W-1], cmd.coords[j]});
         p = d * d;
         sq_in[j] = (j < int'(cfg.eff_c)) ? p[SQ_W-1:0] : '0;
         dist_in  = dist_in + DIST_W'(sq_ff[j]);
      end
   end

   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      best_dist_in  = best_dist_ff;
      best_idx_in   = best_idx_ff;
      best_valid_in = best_valid_ff;
      iter_in       = iter_ff;
      new_idx_in    = new_idx_ff;
      newl_in       = newl_ff;
      q_idx_in      = q_idx_ff;
      q_dist_in     = q_dist_ff;
      q_valid_in    = q_valid_ff;
      rank_in       = rank_ff;
      dropped_in    = dropped_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp.ready;
      rsp_in        = rsp_ff;
      store_we      = 1'b0;
      list_we       = 1'b0;
      list_wa       = iter_ff;
      list_wd       = off_i;
      cmd_pop       = 1'b0;

      unique case (state_ff)
         S_IDLE: begin
            dropped_in = 1'b0;
            if (cmd_valid) begin
               unique case (cmd.op)
                  OP_ADD: state_in = S_ADD_INIT;
                  OP_CLEAR: begin
                     count_in      = '0;
                     best_dist_in  = DIST_NONE;
                     best_idx_in   = '0;
                     best_valid_in = 1'b0;
                     state_in      = S_EMIT;
                  end
                  OP_QBEST: begin
                     q_idx_in   = best_idx_ff;
                     q_dist_in  = best_dist_ff;
                     q_valid_in = best_valid_ff;
                     state_in   = S_Q_ROW;
                  end
                  OP_QWORST: begin
                     q_idx_in   = '0;
                     q_dist_in  = DIST_NONE;
                     q_valid_in = 1'b0;
                     iter_in    = '0;
                     state_in   = (count_ff == '0) ? S_Q_ROW : S_WS_RD;
                  end
                  default: state_in = S_IDLE;
               endcase
            end
         end
         S_ADD_INIT: begin
            if (count_ff == CNT_W'(MAX_POINTS)) begin
               dropped_in = 1'b1;
               state_in   = S_EMIT;
            end else begin
               store_we   = 1'b1;
               new_idx_in = count_ff[IDX_W-1:0];
               count_in   = count_ff + CNT_W'(1);
               newl_in    = empty_row;
               iter_in    = '0;
               state_in   = (count_ff == '0) ? S_ADD_WB : S_RD;
            end
         end
         S_RD:  state_in = S_SQ;
         S_SQ:  state_in = S_SUM;
         S_SUM: state_in = S_OFF_I;
         S_OFF_I: begin
            if (hit_i) begin
               list_we = 1'b1;
               if (!best_valid_ff || off_i[0].sq_dist < best_dist_ff) begin
                  best_dist_in  = off_i[0].sq_dist;
                  best_idx_in   = iter_ff;
                  best_valid_in = 1'b1;
               end
            end
            state_in = S_OFF_N;
         end
         S_OFF_N: begin
            if (hit_n) begin
               newl_in = off_n;
               if (!best_valid_ff || off_n[0].sq_dist < best_dist_ff) begin
                  best_dist_in  = off_n[0].sq_dist;
                  best_idx_in   = new_idx_ff;
                  best_valid_in = 1'b1;
               end
            end
            iter_in = iter_ff + IDX_W'(1);
            // count already includes the new point, so stop one short
            state_in = ((CNT_W'(iter_ff) + CNT_W'(2)) == count_ff) ? S_ADD_WB : S_RD;
         end
         S_ADD_WB: begin
            list_we  = 1'b1;
            list_wa  = new_idx_ff;
            list_wd  = newl_ff;
            state_in = S_EMIT;
         end
         S_WS_RD: state_in = S_WS_CMP;
         S_WS_CMP: begin
            if (!q_valid_ff || list_rd_ff[0].sq_dist >= q_dist_ff) begin
               q_dist_in  = list_rd_ff[0].sq_dist;
               q_idx_in   = iter_ff;
               q_valid_in = 1'b1;
            end
            iter_in  = iter_ff + IDX_W'(1);
            state_in = last_iter ? S_Q_ROW : S_WS_RD;
         end
         S_Q_ROW: begin
            rank_in  = '0;
            state_in = S_Q_ID;
         end
         S_Q_ID: state_in = S_Q_OUT;
         S_Q_OUT: begin
            if (out_free) begin
               rsp_valid_in           = 1'b1;
               rsp_in.entry_count     = CNT_OUT_W'(count_ff);
               rsp_in.entry_index     = IDX_OUT_W'(q_idx_ff);
               rsp_in.entry_dist      = q_dist_ff;
               rsp_in.entry_valid     = q_valid_ff;
               rsp_in.neighbour_index = nbr_ok ? IDX_OUT_W'(q_slot.who) : '0;
               rsp_in.neighbour_id    = nbr_ok ? id_rd_ff : '0;
               rsp_in.neighbour_valid = nbr_ok;
               rsp_in.store_full      = 1'b0;
               rsp_in.last            = (NK_W'(rank_ff) + NK_W'(1)) == cfg.eff_k;
               if (rsp_in.last) begin
                  cmd_pop  = 1'b1;
                  state_in = S_IDLE;
               end else begin
                  rank_in  = rank_ff + RK_W'(1);
                  state_in = S_Q_ID;
               end
            end
         end
         S_EMIT: begin
            if (out_free) begin
               rsp_valid_in           = 1'b1;
               rsp_in.entry_count     = CNT_OUT_W'(count_ff);
               rsp_in.entry_index     = IDX_OUT_W'(best_idx_ff);
               rsp_in.entry_dist      = best_dist_ff;
               rsp_in.entry_valid     = best_valid_ff;
               rsp_in.neighbour_index = '0;
               rsp_in.neighbour_id    = '0;
               rsp_in.neighbour_valid = 1'b0;
               rsp_in.store_full      = dropped_ff;
               rsp_in.last            = 1'b1;
               cmd_pop                = 1'b1;
               state_in               = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         count_ff      <= '0;
         best_dist_ff  <= DIST_NONE;
         best_idx_ff   <= '0;
         best_valid_ff <= 1'b0;
         dropped_ff    <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         count_ff      <= count_in;
         best_dist_ff  <= best_dist_in;
         best_idx_ff   <= best_idx_in;
         best_valid_ff <= best_valid_in;
         dropped_ff    <= dropped_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      iter_ff    <= iter_in;
      new_idx_ff <= new_idx_in;
      newl_ff    <= newl_in;
      q_idx_ff   <= q_idx_in;
      q_dist_ff  <= q_dist_in;
      q_valid_ff <= q_valid_in;
      rank_ff    <= rank_in;
      rsp_ff     <= rsp_in;
      sq_ff      <= sq_in;
      dist_ff    <= dist_in;
   end

   // point store and neighbour lists
   always_ff @(posedge clock) begin
      if (store_we) begin
         coord_mem[count_ff[IDX_W-1:0]] <= coord_wd;
         id_mem[count_ff[IDX_W-1:0]]    <= cmd.point_id;
      end
      if (list_we) begin
         list_mem[list_wa] <= list_wd;
      end
      coord_rd_ff <= coord_mem[rd_addr];
      list_rd_ff  <= list_mem[rd_addr];
      id_rd_ff    <= id_mem[id_addr];
   end

   assign rsp.valid           = rsp_valid_ff;
   assign rsp.entry_count     = rsp_ff.entry_count;
   assign rsp.entry_index     = rsp_ff.entry_index;
   assign rsp.entry_dist      = rsp_ff.entry_dist;
   assign rsp.entry_valid     = rsp_ff.entry_valid;
   assign rsp.neighbour_index = rsp_ff.neighbour_index;
   assign rsp.neighbour_id    = rsp_ff.neighbour_id;
   assign rsp.neighbour_valid = rsp_ff.neighbour_valid;
   assign rsp.store_full      = rsp_ff.store_full;
   assign rsp.last            = rsp_ff.last;

endmodule

>>> hw/rtl/incremental_knn_density_tracker_unit.sv
// Top level of the k-nearest-neighbour density tracker.
// Depends on knn_pkg, knn_req_if, knn_rsp_if, knn_front, knn_cmd_fifo, knn_back.
//
// Usage:
//   req_chan carries one command per transfer: add a point (id + four signed
//   16-bit coordinates), clear the store, query the densest point or query
//   the sparsest point. rsp_chan returns one result per add or clear and
//   K results (one per neighbour rank, farthest first, last on the final
//   one) per query. csr_we/csr_index/csr_wdata set the coordinate count
//   (index 0) and K (index 1); write them only while the block is idle.
// Operation:
//   Commands are queued two deep ahead of the execution engine, which runs
//   one command at a time. An add steps through each point already stored
//   (read, square, sum, update stored list, update new list). Query worst
//   also steps through every stored point, one at a time, as set by the
//   single read port of the neighbour list memory.
// Reset clears the point count and best tracking; no memory sweep is needed.
// When rsp_chan stalls, the result register holds and execution waits.
module incremental_knn_density_tracker_unit #(
   parameter int MAX_POINTS     = knn_pkg::DEF_MAX_POINTS,
   parameter int MAX_NEIGHBOURS = knn_pkg::DEF_MAX_NEIGHBOURS,
   parameter int MAX_COORDS     = knn_pkg::DEF_MAX_COORDS
) (
   input  logic                          clock,
   input  logic                          reset,
   knn_req_if.sink                       req_chan,
   knn_rsp_if.source                     rsp_chan,
   input  logic                          csr_we,
   input  logic [knn_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [knn_pkg::CSR_DAT_W-1:0] csr_wdata
);
   import knn_pkg::*;

   logic    f_valid, f_ready, b_valid, b_pop;
   cmd_type f_cmd, b_cmd;
   cfg_type cfg;

   knn_front #(
      .MAX_NEIGHBOURS (MAX_NEIGHBOURS),
      .MAX_COORDS     (MAX_COORDS)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .req       (req_chan),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cmd_valid (f_valid),
      .cmd_ready (f_ready),
      .cmd       (f_cmd),
      .cfg       (cfg)
   );

   knn_cmd_fifo #(
      .DEPTH (CMD_QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (f_valid),
      .in_ready  (f_ready),
      .in_data   (f_cmd),
      .out_valid (b_valid),
      .out_ready (b_pop),
      .out_data  (b_cmd)
   );

   knn_back #(
      .MAX_POINTS     (MAX_POINTS),
      .MAX_NEIGHBOURS (MAX_NEIGHBOURS),
      .MAX_COORDS     (MAX_COORDS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (b_valid),
      .cmd_pop   (b_pop),
      .cmd       (b_cmd),
      .cfg       (cfg),
      .rsp       (rsp_chan)
   );

endmodule

>>> hw/rtl/knn_chk.sv
// Port-level checks for the density tracker, bound to the top level.
// Depends on knn_pkg and incremental_knn_density_tracker_unit.
module knn_chk #(
   parameter int MAX_POINTS = knn_pkg::DEF_MAX_POINTS
) (
   input logic                               clock,
   input logic                               reset,
   input logic                               rsp_valid,
   input logic                               rsp_ready,
   input logic [knn_pkg::CNT_OUT_W-1:0]      rsp_entry_count,
   input logic [knn_pkg::DIST_W-1:0]         rsp_entry_dist,
   input logic                               rsp_entry_valid,
   input logic                               rsp_neighbour_valid,
   input logic                               rsp_store_full,
   input logic                               rsp_last
);
   import knn_pkg::*;

   // a stalled transfer keeps its result
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_entry_dist) && $stable(rsp_last))
      else $error("result changed while stalled");

   a_reset_idle: assert property (@(posedge clock)
      !reset && $past(reset) |-> !rsp_valid)
      else $error("result valid straight after reset");

   a_full_drop: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_store_full |->
         rsp_last && !rsp_neighbour_valid && rsp_entry_count == CNT_OUT_W'(MAX_POINTS))
      else $error("dropped add reported with wrong fields");

   a_no_entry: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_entry_valid |-> rsp_entry_dist == DIST_NONE && !rsp_neighbour_valid)
      else $error("neighbour or distance reported without an entry");

endmodule

bind incremental_knn_density_tracker_unit knn_chk #(
   .MAX_POINTS (MAX_POINTS)
) u_knn_chk (
   .clock               (clock),
   .reset               (reset),
   .rsp_valid           (rsp_chan.valid),
   .rsp_ready           (rsp_chan.ready),
   .rsp_entry_count     (rsp_chan.entry_count),
   .rsp_entry_dist      (rsp_chan.entry_dist),
   .rsp_entry_valid     (rsp_chan.entry_valid),
   .rsp_neighbour_valid (rsp_chan.neighbour_valid),
   .rsp_store_full      (rsp_chan.store_full),
   .rsp_last            (rsp_chan.last)
);
